@@ hw/rtl/rgc_pkg.sv @@
`timescale 1ns / 1ps

package rgc_pkg;

  // pattern characters the scanner and the testbench use
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [STATUS_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_STRAY    = 3'd1,
    ERR_UNCLOSED = 3'd2,
    ERR_UNTERM   = 3'd3,
    ERR_ELEMENT  = 3'd4,
    ERR_DEPTH    = 3'd5
  } err_code_t;

  typedef struct packed {
    logic [COUNT_W-1:0] group_count;
    err_code_t          status;
  } rgc_result_t;

endpackage

@@ hw/rtl/regex_group_counter.sv @@
`timescale 1ns / 1ps

// Counts the capture groups of a POSIX regex fed one byte per beat on the in_
// channel, with in_tlast on the final byte of each pattern. One byte is taken
// every cycle unless the stall below holds; the scan state, depth and count update
// from the input register, so throughput is one byte per clock outside that
// stall. The only stall is a final byte that waits in the input register while
// the previous result beat is still held on the out_ channel. For each pattern a
// single result beat is loaded into the result register from the input register
// holding its last byte and shown on out_, carrying the group count and
// status (0 ok, 1 stray close, 2 unclosed group, 3 unterminated bracket or
// escape, 4 bad class element, 5 depth overflow). After an error the remaining
// bytes of that pattern are skipped and the count stays where the error was
// found. The scanner starts clean for the next pattern. Nesting deeper than
// MAX_DEPTH open groups is an error.
module regex_group_counter #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pattern_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] group_count, [18:16] status, [23:19] zero
);

  logic                 in_vld_r;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic                 out_vld_r;
  rgc_pkg::rgc_result_t out_res_r;
  rgc_pkg::rgc_result_t scan_res;
  logic                 out_free;
  logic                 step;

  assign out_free  = !out_vld_r || out_tready;
  // a non-final byte never waits on the result side
  assign step      = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || step;

  rgc_scan #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .pattern_byte (in_byte_r),
    .last_byte    (in_last_r),
    .result       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (step && in_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step && in_last_r) begin
      out_res_r <= scan_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(rgc_pkg::OUT_DATA_W - rgc_pkg::COUNT_W - rgc_pkg::STATUS_W)'(0),
                       out_res_r.status, out_res_r.group_count};

endmodule

@@ hw/rtl/rgc_scan.sv @@
`timescale 1ns / 1ps

module rgc_scan #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           pattern_byte,
  input  logic                 last_byte,
  output rgc_pkg::rgc_result_t result
);

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  typedef enum logic [3:0] {
    S_NORMAL,
    S_ESCAPE,
    S_BFIRST,
    S_BBODY,
    S_BLBRACK,
    S_DOTSCAN,
    S_DOTEND,
    S_COLSCAN,
    S_COLEND,
    S_EQSCAN,
    S_EQEND
  } scan_st_t;

  scan_st_t                     st_r, st_nxt;
  logic [DEPTH_W-1:0]           depth_r, depth_nxt;
  logic [rgc_pkg::COUNT_W-1:0]  groups_r, groups_nxt;
  rgc_pkg::err_code_t           err_r, err_nxt, err_fin;
  scan_st_t                     body_st;
  logic                         in_element;

  // ordinary bracket member, not in first place
  always_comb begin
    if (pattern_byte == rgc_pkg::CH_RBRACK) begin
      body_st = S_NORMAL;
    end else if (pattern_byte == rgc_pkg::CH_LBRACK) begin
      body_st = S_BLBRACK;
    end else begin
      body_st = S_BBODY;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    depth_nxt  = depth_r;
    groups_nxt = groups_r;
    err_nxt    = err_r;
    if (err_r == rgc_pkg::ERR_NONE) begin
      case (st_r)
        S_NORMAL: begin
          if (pattern_byte == rgc_pkg::CH_LBRACK) begin
            st_nxt = S_BFIRST;
          end else if (pattern_byte == rgc_pkg::CH_BSLASH) begin
            st_nxt = S_ESCAPE;
          end else if (pattern_byte == rgc_pkg::CH_LPAREN) begin
            if (depth_r >= DEPTH_MAX) begin
              err_nxt = rgc_pkg::ERR_DEPTH;
            end else begin
              depth_nxt = depth_r + 1'b1;
            end
          end else if (pattern_byte == rgc_pkg::CH_RPAREN) begin
            if (depth_r == '0) begin
              err_nxt = rgc_pkg::ERR_STRAY;
            end else begin
              depth_nxt = depth_r - 1'b1;
              if (groups_r != '1) begin
                groups_nxt = groups_r + 1'b1;
              end
            end
          end
        end
        S_ESCAPE: begin
          st_nxt = S_NORMAL;
        end
        S_BFIRST: begin
          // leading ']' or '-' is a literal member
          if (pattern_byte == rgc_pkg::CH_LBRACK) begin
            st_nxt = S_BLBRACK;
          end else begin
            st_nxt = S_BBODY;
          end
        end
        S_BBODY: begin
          st_nxt = body_st;
        end
        S_BLBRACK: begin
          if (pattern_byte == rgc_pkg::CH_DOT) begin
            st_nxt = S_DOTSCAN;
          end else if (pattern_byte == rgc_pkg::CH_COLON) begin
            st_nxt = S_COLSCAN;
          end else if (pattern_byte == rgc_pkg::CH_EQUAL) begin
            st_nxt = S_EQSCAN;
          end else begin
            st_nxt = body_st;
          end
        end
        S_DOTSCAN: begin
          if (pattern_byte == rgc_pkg::CH_DOT) begin
            st_nxt = S_DOTEND;
          end
        end
        S_COLSCAN: begin
          if (pattern_byte == rgc_pkg::CH_COLON) begin
            st_nxt = S_COLEND;
          end
        end
        S_EQSCAN: begin
          if (pattern_byte == rgc_pkg::CH_EQUAL) begin
            st_nxt = S_EQEND;
          end
        end
        S_DOTEND, S_COLEND, S_EQEND: begin
          if (pattern_byte == rgc_pkg::CH_RBRACK) begin
            st_nxt = S_BBODY;
          end else begin
            err_nxt = rgc_pkg::ERR_ELEMENT;
          end
        end
        default: begin
          st_nxt = S_NORMAL;
        end
      endcase
    end
  end

  assign in_element = (st_nxt == S_DOTSCAN) || (st_nxt == S_DOTEND) ||
                      (st_nxt == S_COLSCAN) || (st_nxt == S_COLEND) ||
                      (st_nxt == S_EQSCAN)  || (st_nxt == S_EQEND);

  // end-of-pattern checks
  always_comb begin
    err_fin = err_nxt;
    if (err_nxt == rgc_pkg::ERR_NONE) begin
      if (in_element) begin
        err_fin = rgc_pkg::ERR_ELEMENT;
      end else if (st_nxt != S_NORMAL) begin
        err_fin = rgc_pkg::ERR_UNTERM;
      end else if (depth_nxt != '0) begin
        err_fin = rgc_pkg::ERR_UNCLOSED;
      end
    end
  end

  assign result.group_count = groups_nxt;
  assign result.status      = err_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_NORMAL;
      depth_r  <= '0;
      groups_r <= '0;
      err_r    <= rgc_pkg::ERR_NONE;
    end else if (step) begin
      if (last_byte) begin
        st_r     <= S_NORMAL;
        depth_r  <= '0;
        groups_r <= '0;
        err_r    <= rgc_pkg::ERR_NONE;
      end else begin
        st_r     <= st_nxt;
        depth_r  <= depth_nxt;
        groups_r <= groups_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_MAX)
    else $error("nesting depth above limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> depth_r == '0 && groups_r == '0 &&
                          err_r == rgc_pkg::ERR_NONE && st_r == S_NORMAL)
    else $error("scanner not cleared after end of pattern");

  a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != rgc_pkg::ERR_NONE && !(step && last_byte) |=>
      $stable(groups_r) && $stable(err_r) && $stable(depth_r))
    else $error("scanner state moved after an error");

  a_sticky_status: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != rgc_pkg::ERR_NONE |-> result.status == err_r)
    else $error("first error not reported");

endmodule

@@ test/rgc_checker.sv @@
`timescale 1ns / 1ps

module rgc_checker #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          mismatches,
  output int          results_seen,
  output int          results_owed
);

  // parse states, element states come last so one compare finds them
  typedef enum logic [3:0] {
    SC_NORMAL, SC_ESCAPE, SC_BFIRST, SC_BBODY, SC_BLBRACK,
    SC_DOTSCAN, SC_DOTEND, SC_COLSCAN, SC_COLEND, SC_EQSCAN, SC_EQEND
  } scan_t;

  scan_t                 scan;
  int unsigned           depth;
  logic [15:0]           groups;
  rgc_pkg::err_code_t    err;
  rgc_pkg::rgc_result_t  owed_q[$];
  rgc_pkg::rgc_result_t  want;

  function automatic void clear_scan();
    scan   = SC_NORMAL;
    depth  = 0;
    groups = '0;
    err    = rgc_pkg::ERR_NONE;
  endfunction

  function automatic void flag(input rgc_pkg::err_code_t code);
    if (err == rgc_pkg::ERR_NONE) err = code;
  endfunction

  function automatic void bracket_member(input logic [7:0] c);
    if (c == rgc_pkg::CH_RBRACK) scan = SC_NORMAL;
    else if (c == rgc_pkg::CH_LBRACK) scan = SC_BLBRACK;
    else scan = SC_BBODY;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    case (scan)
      SC_NORMAL: begin
        if (c == rgc_pkg::CH_LBRACK) scan = SC_BFIRST;
        else if (c == rgc_pkg::CH_BSLASH) scan = SC_ESCAPE;
        else if (c == rgc_pkg::CH_LPAREN) begin
          if (depth >= MAX_DEPTH) flag(rgc_pkg::ERR_DEPTH);
          else depth++;
        end else if (c == rgc_pkg::CH_RPAREN) begin
          if (depth == 0) flag(rgc_pkg::ERR_STRAY);
          else begin
            depth--;
            if (groups != 16'hFFFF) groups++;
          end
        end
      end
      SC_ESCAPE: scan = SC_NORMAL;
      // ']' or '-' right after the opener is a plain member
      SC_BFIRST: scan = (c == rgc_pkg::CH_LBRACK) ? SC_BLBRACK : SC_BBODY;
      SC_BBODY: bracket_member(c);
      SC_BLBRACK: begin
        if (c == rgc_pkg::CH_DOT) scan = SC_DOTSCAN;
        else if (c == rgc_pkg::CH_COLON) scan = SC_COLSCAN;
        else if (c == rgc_pkg::CH_EQUAL) scan = SC_EQSCAN;
        else bracket_member(c);
      end
      SC_DOTSCAN: if (c == rgc_pkg::CH_DOT) scan = SC_DOTEND;
      SC_COLSCAN: if (c == rgc_pkg::CH_COLON) scan = SC_COLEND;
      SC_EQSCAN: if (c == rgc_pkg::CH_EQUAL) scan = SC_EQEND;
      SC_DOTEND, SC_COLEND, SC_EQEND: begin
        if (c == rgc_pkg::CH_RBRACK) scan = SC_BBODY;
        else flag(rgc_pkg::ERR_ELEMENT);
      end
      default: scan = SC_NORMAL;
    endcase
  endfunction

  function automatic void take_byte(input logic [7:0] c, input logic last);
    rgc_pkg::rgc_result_t r;
    if (err == rgc_pkg::ERR_NONE) scan_char(c);
    if (last) begin
      if (err == rgc_pkg::ERR_NONE) begin
        if (scan >= SC_DOTSCAN) flag(rgc_pkg::ERR_ELEMENT);
        else if (scan != SC_NORMAL) flag(rgc_pkg::ERR_UNTERM);
        else if (depth != 0) flag(rgc_pkg::ERR_UNCLOSED);
      end
      r.group_count = groups;
      r.status      = err;
      owed_q.push_back(r);
      clear_scan();
    end
  endfunction

  function automatic void report(input string what, input int e_cnt, input int e_st,
                                 input int g_cnt, input int g_st);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: group_count exp %0d got %0d, status exp %0d got %0d",
               $realtime, what, e_cnt, g_cnt, e_st, g_st);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      owed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (owed_q.size() == 0) begin
          report("result beat with none owed", -1, -1,
                 int'(out_tdata[15:0]), int'(out_tdata[18:16]));
        end else begin
          want = owed_q.pop_front();
          if (out_tdata[15:0] != want.group_count || out_tdata[18:16] != want.status)
            report("result mismatch", int'(want.group_count), int'(want.status),
                   int'(out_tdata[15:0]), int'(out_tdata[18:16]));
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
    end
    results_owed = owed_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH_LIMIT = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 350;
  localparam int IDLE_PCT [4]  = '{0, 45, 0, 14};
  localparam int STALL_PCT [4] = '{0, 0, 45, 14};
  localparam logic [7:0] SPECIALS [9] = '{rgc_pkg::CH_LPAREN, rgc_pkg::CH_RPAREN,
                                          rgc_pkg::CH_LBRACK, rgc_pkg::CH_RBRACK,
                                          rgc_pkg::CH_DASH, rgc_pkg::CH_BSLASH,
                                          rgc_pkg::CH_DOT, rgc_pkg::CH_COLON,
                                          rgc_pkg::CH_EQUAL};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] pattern_byte
  logic        in_tlast   = 1'b0;   // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [15:0] group_count, [18:16] status

  int mismatches, results_seen, results_owed;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int lasts_sent = 0;
  int quiet_cycles = 0;
  logic [7:0] pat[$];

  regex_group_counter #(.MAX_DEPTH(DEPTH_LIMIT)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rgc_checker #(.MAX_DEPTH(DEPTH_LIMIT)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .results_seen(results_seen),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (last) lasts_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_pattern();
    for (int i = 0; i < pat.size(); i++) put_byte(pat[i], i == pat.size() - 1);
  endtask

  // hold the sender off until every owed result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (results_seen == lasts_sent);
    @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c inside {SPECIALS});
    return c;
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] m);
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == m);
    return c;
  endfunction

  // [.x.], [:x:] or [=x=] with a short body
  function automatic void add_element();
    logic [7:0] m;
    int n;
    m = SPECIALS[$urandom_range(6, 8)];
    n = $urandom_range(3);
    pat.push_back(rgc_pkg::CH_LBRACK);
    pat.push_back(m);
    repeat (n) pat.push_back(any_but(m));
    pat.push_back(m);
    pat.push_back(rgc_pkg::CH_RBRACK);
  endfunction

  function automatic void add_bracket();
    int n;
    n = $urandom_range(4);
    pat.push_back(rgc_pkg::CH_LBRACK);
    case ($urandom_range(4))
      0: pat.push_back(rgc_pkg::CH_RBRACK);
      1: pat.push_back(rgc_pkg::CH_DASH);
      2: begin
        pat.push_back(rgc_pkg::CH_LBRACK);
        pat.push_back(plain_char());
      end
      default: if (n == 0) n = 1;
    endcase
    repeat (n) begin
      case ($urandom_range(6))
        0, 1: pat.push_back(plain_char());
        2: pat.push_back(SPECIALS[$urandom_range(0, 1)]);
        3: pat.push_back(SPECIALS[$urandom_range(4, 8)]);
        4: begin
          pat.push_back(rgc_pkg::CH_LBRACK);
          pat.push_back(plain_char());
        end
        default: add_element();
      endcase
    end
    pat.push_back(rgc_pkg::CH_RBRACK);
  endfunction

  function automatic void add_noise(input int n);
    repeat (n) begin
      if ($urandom_range(1)) pat.push_back(8'($urandom_range(255)));
      else pat.push_back(SPECIALS[$urandom_range(8)]);
    end
  endfunction

  function automatic void build_pattern();
    int depth;
    pat.delete();
    depth = 0;
    if ($urandom_range(9) < 3) begin
      add_noise($urandom_range(1, 12));
      return;
    end
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(9))
        0, 1, 2: pat.push_back(plain_char());
        3: begin
          pat.push_back(rgc_pkg::CH_BSLASH);
          pat.push_back(8'($urandom_range(255)));
        end
        4, 5: begin
          if (depth < DEPTH_LIMIT) begin
            pat.push_back(rgc_pkg::CH_LPAREN);
            depth++;
          end else pat.push_back(plain_char());
        end
        6: begin
          if (depth > 0) begin
            pat.push_back(rgc_pkg::CH_RPAREN);
            depth--;
          end else pat.push_back(plain_char());
        end
        7, 8: add_bracket();
        default: pat.push_back(SPECIALS[$urandom_range(3, 8)]);
      endcase
    end
    repeat (depth) pat.push_back(rgc_pkg::CH_RPAREN);
    case ($urandom_range(11))
      0: begin
        pat.push_back(rgc_pkg::CH_RPAREN);
        add_noise($urandom_range(3));
      end
      1: pat.push_back(rgc_pkg::CH_LPAREN);
      2: pat.push_back(rgc_pkg::CH_BSLASH);
      3: begin
        pat.push_back(rgc_pkg::CH_LBRACK);
        pat.push_back(plain_char());
      end
      4: begin
        // element mark not followed by its closing bracket
        pat.push_back(rgc_pkg::CH_LBRACK);
        pat.push_back(rgc_pkg::CH_LBRACK);
        pat.push_back(rgc_pkg::CH_DOT);
        pat.push_back(plain_char());
        pat.push_back(rgc_pkg::CH_DOT);
        pat.push_back(plain_char());
        add_noise($urandom_range(3));
      end
      5: begin
        pat.push_back(rgc_pkg::CH_LBRACK);
        pat.push_back(rgc_pkg::CH_LBRACK);
        pat.push_back(rgc_pkg::CH_EQUAL);
        pat.push_back(plain_char());
      end
      6: begin
        repeat (DEPTH_LIMIT + $urandom_range(1, 2)) pat.push_back(rgc_pkg::CH_LPAREN);
        add_noise($urandom_range(3));
      end
      7: begin
        repeat (DEPTH_LIMIT) pat.push_back(rgc_pkg::CH_LPAREN);
        repeat (DEPTH_LIMIT) pat.push_back(rgc_pkg::CH_RPAREN);
      end
      default: ;
    endcase
  endfunction

  initial begin
    int phase_bytes;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_text("(\\)");
    send_text(")");
    send_text("[]]");
    send_text("[-]");
    send_text("[[.a.]]");
    send_text("[[:a");
    put_byte(8'hFF, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_pattern();
        send_pattern();
        phase_bytes += pat.size();
      end
      drain();
    end

    repeat (10) @(posedge clk);

    if (mismatches == 0 && results_owed == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
